// File: rtl/core/bmprgb_pkg.sv
// types and constants shared by the bitmap to rgb565 bus streamer
`timescale 1ns / 1ps
`default_nettype none

package bmprgb_pkg;

    // field and register widths
    localparam int CoordW   = 10;
    localparam int ImgSizeW = 13;
    localparam int CfgDataW = 13;
    localparam int CfgIdxW  = 2;
    localparam int ByteW    = 8;
    localparam int ColorW   = 16;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgXStart      = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgYStart      = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgImageWidth  = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgImageHeight = 2'd3;

    // register values after reset
    localparam logic [CoordW-1:0]   XStartInit      = 10'd0;
    localparam logic [CoordW-1:0]   YStartInit      = 10'd0;
    localparam logic [ImgSizeW-1:0] ImageWidthInit  = 13'd320;
    localparam logic [ImgSizeW-1:0] ImageHeightInit = 13'd480;

    // panel commands
    localparam logic [ByteW-1:0] CmdColumnSet = 8'h2A;
    localparam logic [ByteW-1:0] CmdPageSet   = 8'h2B;
    localparam logic [ByteW-1:0] CmdMemWrite  = 8'h2C;

    // input operation codes
    localparam logic OpStart = 1'b0;
    localparam logic OpData  = 1'b1;

    // job queue between front and back
    localparam int QDepth = 4;
    localparam int QPtrW  = 2;

    // byte positions inside a job
    localparam int JobIdxW = 4;
    localparam logic [JobIdxW-1:0] WinColHi  = 4'd1;
    localparam logic [JobIdxW-1:0] WinColLo  = 4'd2;
    localparam logic [JobIdxW-1:0] WinColEHi = 4'd3;
    localparam logic [JobIdxW-1:0] WinColELo = 4'd4;
    localparam logic [JobIdxW-1:0] WinPage   = 4'd5;
    localparam logic [JobIdxW-1:0] WinRowHi  = 4'd6;
    localparam logic [JobIdxW-1:0] WinRowLo  = 4'd7;
    localparam logic [JobIdxW-1:0] WinRowEHi = 4'd8;
    localparam logic [JobIdxW-1:0] WinRowELo = 4'd9;
    localparam logic [JobIdxW-1:0] WinLast   = 4'd10;
    localparam logic [JobIdxW-1:0] PixLast   = 4'd1;
    localparam logic [JobIdxW-1:0] JobFirst  = 4'd0;

    typedef struct packed {
        logic             op;
        logic [ByteW-1:0] pixel_byte;
    } in_item_t;

    typedef struct packed {
        logic [ByteW-1:0] bus_byte;
        logic             is_data;
        logic             last;
    } out_item_t;

    typedef enum logic {
        JOB_WINDOW,
        JOB_PIXEL
    } job_kind_t;

    typedef struct packed {
        job_kind_t         kind;
        logic [CoordW-1:0] x0;
        logic [CoordW-1:0] x1;
        logic [CoordW-1:0] y0;
        logic [CoordW-1:0] y1;
        logic [ColorW-1:0] color;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        PH_BLUE,
        PH_GREEN,
        PH_RED
    } phase_t;

endpackage

`default_nettype wire

// File: rtl/core/bmp24_to_rgb565_bus_streamer.sv
// top level of the 24-bit bitmap to rgb565 parallel panel bus streamer
// usage:
//   item channel (item_valid, item_stall, item_data): op 0 starts an image and
//   queues the window commands, op 1 carries one bitmap row byte (b, g, r, pad).
//   bus channel (bus_valid, bus_stall, bus_data): one panel bus byte per
//   transaction with its data/command flag and a last flag on each job's final byte.
//   cfg port (cfg_write, cfg_index, cfg_data): x_start, y_start, image_width,
//   image_height; write only while the block is idle.
// throughput: one input transaction per cycle while the four-entry job queue
//   has room; the bus side sends one byte per cycle while bus_stall is low, so a
//   pixel (3 input bytes, 2 bus bytes) keeps pace, and a start item queues 11 bus bytes.
// path: an accepted item is written into the job queue, then its first bus byte is
//   loaded into the output register, from which the bus takes it.
// reset: config returns to 0, 0, 320, 480, drawing stops, the queue empties.
// a stalled bus holds its byte; the front keeps taking items until the queue
//   fills, then raises item_stall.
`timescale 1ns / 1ps
`default_nettype none

module bmp24_to_rgb565_bus_streamer #(
    parameter int PANEL_WIDTH     = 320,
    parameter int PANEL_HEIGHT    = 480,
    parameter int MAX_IMAGE_WIDTH = 4096
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_write,
    input  wire  [bmprgb_pkg::CfgIdxW-1:0]    cfg_index,
    input  wire  [bmprgb_pkg::CfgDataW-1:0]   cfg_data,
    input  wire                               item_valid,
    output logic                              item_stall,
    input  bmprgb_pkg::in_item_t              item_data,
    output logic                              bus_valid,
    input  wire                               bus_stall,
    output bmprgb_pkg::out_item_t             bus_data
);

    logic                   q_push;
    logic                   q_pop;
    bmprgb_pkg::job_t       q_job;
    bmprgb_pkg::job_t       head_job;
    bmprgb_pkg::q_status_t  q_status;

    bmprgb_front #(
        .PANEL_WIDTH     (PANEL_WIDTH),
        .PANEL_HEIGHT    (PANEL_HEIGHT),
        .MAX_IMAGE_WIDTH (MAX_IMAGE_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_data  (item_data),
        .q_status   (q_status),
        .q_push     (q_push),
        .q_job      (q_job)
    );

    bmprgb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .head_job (head_job),
        .status   (q_status)
    );

    bmprgb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_status  (q_status),
        .pop       (q_pop),
        .bus_valid (bus_valid),
        .bus_stall (bus_stall),
        .bus_data  (bus_data)
    );

endmodule

`default_nettype wire

// File: rtl/core/bmprgb_front.sv
// front end: configuration registers, crop setup, row byte counting and job issue
`timescale 1ns / 1ps
`default_nettype none

module bmprgb_front #(
    parameter int PANEL_WIDTH     = 320,
    parameter int PANEL_HEIGHT    = 480,
    parameter int MAX_IMAGE_WIDTH = 4096
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_write,
    input  wire  [bmprgb_pkg::CfgIdxW-1:0]       cfg_index,
    input  wire  [bmprgb_pkg::CfgDataW-1:0]      cfg_data,
    input  wire                                  item_valid,
    output logic                                 item_stall,
    input  bmprgb_pkg::in_item_t                 item_data,
    input  bmprgb_pkg::q_status_t                q_status,
    output logic                                 q_push,
    output bmprgb_pkg::job_t                     q_job
);

    localparam int ImgMax = (1 << bmprgb_pkg::ImgSizeW) - 1;
    localparam int EffMax = (MAX_IMAGE_WIDTH < ImgMax) ? MAX_IMAGE_WIDTH : ImgMax;
    localparam int EffW   = $clog2(EffMax + 1);
    localparam int RbW    = $clog2(3 * EffMax + 4);
    localparam int PixW   = $clog2(EffMax + 2);
    localparam int CwW    = $clog2(PANEL_WIDTH + 1);
    localparam int ChW    = $clog2(PANEL_HEIGHT + 1);
    localparam int CmpW   = (PixW > CwW) ? PixW : CwW;
    localparam int SumW   = bmprgb_pkg::ImgSizeW + 1;
    localparam int CW     = bmprgb_pkg::CoordW;

    // configuration registers
    logic [CW-1:0]                   x_start_reg;
    logic [CW-1:0]                   y_start_reg;
    logic [bmprgb_pkg::ImgSizeW-1:0] image_width_reg;
    logic [bmprgb_pkg::ImgSizeW-1:0] image_height_reg;

    // image state
    logic                      drawing_reg, drawing_next;
    logic [CwW-1:0]            crop_w_reg, crop_w_next;
    logic [ChW-1:0]            crop_h_reg, crop_h_next;
    logic [RbW-1:0]            byte_in_row_reg, byte_in_row_next;
    logic [PixW-1:0]           pix_reg, pix_next;
    bmprgb_pkg::phase_t        phase_reg, phase_next;
    logic [ChW-1:0]            rows_done_reg, rows_done_next;
    logic [bmprgb_pkg::ByteW-1:0] held_blue_reg, held_blue_next;
    logic [bmprgb_pkg::ByteW-1:0] held_green_reg, held_green_next;

    logic                            accept;
    logic [EffW-1:0]                 eff_w;
    logic [bmprgb_pkg::ImgSizeW-1:0] eff_h;
    logic [SumW-1:0]                 x_sum, y_sum;
    logic                            off_panel;
    logic [CwW-1:0]                  new_crop_w;
    logic [ChW-1:0]                  new_crop_h;
    logic [CW-1:0]                   x_end, y_end;
    logic [RbW-1:0]                  w3, rb_sum, row_bytes, p_plus;
    logic                            row_end, in_image, pix_in_crop, rows_live;

    assign item_stall = q_status.full;
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_start_reg      <= bmprgb_pkg::XStartInit;
            y_start_reg      <= bmprgb_pkg::YStartInit;
            image_width_reg  <= bmprgb_pkg::ImageWidthInit;
            image_height_reg <= bmprgb_pkg::ImageHeightInit;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bmprgb_pkg::CfgXStart:      x_start_reg      <= cfg_data[CW-1:0];
                bmprgb_pkg::CfgYStart:      y_start_reg      <= cfg_data[CW-1:0];
                bmprgb_pkg::CfgImageWidth:  image_width_reg  <= cfg_data;
                bmprgb_pkg::CfgImageHeight: image_height_reg <= cfg_data;
            endcase
        end
    end

    // effective size: zero counts as one, width clipped to the supported maximum
    always_comb
    begin
        if (image_width_reg == '0)
            eff_w = EffW'(1);
        else if (image_width_reg > bmprgb_pkg::ImgSizeW'(EffMax))
            eff_w = EffW'(EffMax);
        else
            eff_w = EffW'(image_width_reg);
        eff_h = (image_height_reg == '0) ? bmprgb_pkg::ImgSizeW'(1) : image_height_reg;
    end

    // crop window against the panel
    assign off_panel = (SumW'(x_start_reg) >= SumW'(PANEL_WIDTH))
                    || (SumW'(y_start_reg) >= SumW'(PANEL_HEIGHT));
    assign x_sum = SumW'(x_start_reg) + SumW'(eff_w);
    assign y_sum = SumW'(y_start_reg) + SumW'(eff_h);
    assign new_crop_w = (x_sum > SumW'(PANEL_WIDTH))
                      ? CwW'(SumW'(PANEL_WIDTH) - SumW'(x_start_reg)) : CwW'(eff_w);
    assign new_crop_h = (y_sum > SumW'(PANEL_HEIGHT))
                      ? ChW'(SumW'(PANEL_HEIGHT) - SumW'(y_start_reg)) : ChW'(eff_h);
    assign x_end = CW'(SumW'(x_start_reg) + SumW'(new_crop_w) - SumW'(1));
    assign y_end = CW'(SumW'(y_start_reg) + SumW'(new_crop_h) - SumW'(1));

    // row length follows the current width register, padded to four bytes
    assign w3        = RbW'({eff_w, 1'b0}) + RbW'(eff_w);
    assign rb_sum    = w3 + RbW'(3);
    assign row_bytes = {rb_sum[RbW-1:2], 2'b00};
    assign p_plus    = byte_in_row_reg + RbW'(1);
    assign row_end   = p_plus >= row_bytes;
    assign in_image  = byte_in_row_reg < w3;
    assign pix_in_crop = CmpW'(pix_reg) < CmpW'(crop_w_reg);
    assign rows_live = drawing_reg && (rows_done_reg < crop_h_reg);

    always_comb
    begin
        drawing_next     = drawing_reg;
        crop_w_next      = crop_w_reg;
        crop_h_next      = crop_h_reg;
        byte_in_row_next = byte_in_row_reg;
        pix_next         = pix_reg;
        phase_next       = phase_reg;
        rows_done_next   = rows_done_reg;
        held_blue_next   = held_blue_reg;
        held_green_next  = held_green_reg;
        q_push           = 1'b0;
        q_job.kind       = bmprgb_pkg::JOB_WINDOW;
        q_job.x0         = x_start_reg;
        q_job.x1         = x_end;
        q_job.y0         = y_start_reg;
        q_job.y1         = y_end;
        // rgb565: red top five, green top six, blue top five
        q_job.color      = {item_data.pixel_byte[7:3], held_green_reg[7:2],
                            held_blue_reg[7:3]};

        if (accept)
        begin
            if (item_data.op == bmprgb_pkg::OpStart)
            begin
                if (off_panel)
                begin
                    drawing_next = 1'b0;
                end
                else
                begin
                    drawing_next     = 1'b1;
                    crop_w_next      = new_crop_w;
                    crop_h_next      = new_crop_h;
                    byte_in_row_next = '0;
                    pix_next         = '0;
                    phase_next       = bmprgb_pkg::PH_BLUE;
                    rows_done_next   = '0;
                    held_blue_next   = '0;
                    held_green_next  = '0;
                    q_push           = 1'b1;
                end
            end
            else if (rows_live)
            begin
                if (in_image)
                begin
                    unique case (phase_reg)
                        bmprgb_pkg::PH_BLUE:  held_blue_next  = item_data.pixel_byte;
                        bmprgb_pkg::PH_GREEN: held_green_next = item_data.pixel_byte;
                        bmprgb_pkg::PH_RED:
                        begin
                            if (pix_in_crop)
                            begin
                                q_push     = 1'b1;
                                q_job.kind = bmprgb_pkg::JOB_PIXEL;
                            end
                        end
                        default: ;
                    endcase
                end

                if (row_end)
                begin
                    byte_in_row_next = '0;
                    pix_next         = '0;
                    phase_next       = bmprgb_pkg::PH_BLUE;
                    rows_done_next   = rows_done_reg + ChW'(1);
                end
                else
                begin
                    byte_in_row_next = p_plus;
                    unique case (phase_reg)
                        bmprgb_pkg::PH_BLUE:  phase_next = bmprgb_pkg::PH_GREEN;
                        bmprgb_pkg::PH_GREEN: phase_next = bmprgb_pkg::PH_RED;
                        bmprgb_pkg::PH_RED:
                        begin
                            phase_next = bmprgb_pkg::PH_BLUE;
                            pix_next   = pix_reg + PixW'(1);
                        end
                        default: phase_next = bmprgb_pkg::PH_BLUE;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drawing_reg     <= 1'b0;
            crop_w_reg      <= '0;
            crop_h_reg      <= '0;
            byte_in_row_reg <= '0;
            pix_reg         <= '0;
            phase_reg       <= bmprgb_pkg::PH_BLUE;
            rows_done_reg   <= '0;
        end
        else
        begin
            drawing_reg     <= drawing_next;
            crop_w_reg      <= crop_w_next;
            crop_h_reg      <= crop_h_next;
            byte_in_row_reg <= byte_in_row_next;
            pix_reg         <= pix_next;
            phase_reg       <= phase_next;
            rows_done_reg   <= rows_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_blue_reg  <= held_blue_next;
        held_green_reg <= held_green_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/bmprgb_queue.sv
// short job queue between the front and back ends
`timescale 1ns / 1ps
`default_nettype none

module bmprgb_queue (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    push,
    input  bmprgb_pkg::job_t       push_job,
    input  wire                    pop,
    output bmprgb_pkg::job_t       head_job,
    output bmprgb_pkg::q_status_t  status
);

    localparam int PW = bmprgb_pkg::QPtrW;

    bmprgb_pkg::job_t entry_reg [bmprgb_pkg::QDepth];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == (PW + 1)'(bmprgb_pkg::QDepth));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_job     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (PW + 1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (PW + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

// File: rtl/core/bmprgb_back.sv
// back end: expands queued jobs into panel bus bytes through an output register
`timescale 1ns / 1ps
`default_nettype none

module bmprgb_back (
    input  wire                    clk,
    input  wire                    rst_n,
    input  bmprgb_pkg::job_t       head_job,
    input  bmprgb_pkg::q_status_t  q_status,
    output logic                   pop,
    output logic                   bus_valid,
    input  wire                    bus_stall,
    output bmprgb_pkg::out_item_t  bus_data
);

    logic [bmprgb_pkg::JobIdxW-1:0] idx_reg, idx_next;
    logic                           valid_reg, valid_next;
    bmprgb_pkg::out_item_t          data_reg, data_next;
    logic                           load;
    logic                           job_done;
    bmprgb_pkg::out_item_t          cur_byte;

    assign load = !valid_reg || !bus_stall;

    // byte selected by the position inside the head job
    always_comb
    begin
        cur_byte.is_data  = 1'b1;
        cur_byte.last     = 1'b0;
        cur_byte.bus_byte = '0;
        if (head_job.kind == bmprgb_pkg::JOB_PIXEL)
        begin
            job_done = (idx_reg == bmprgb_pkg::PixLast);
            cur_byte.bus_byte = job_done ? head_job.color[7:0] : head_job.color[15:8];
        end
        else
        begin
            job_done = (idx_reg == bmprgb_pkg::WinLast);
            unique case (idx_reg)
                bmprgb_pkg::JobFirst:
                begin
                    cur_byte.bus_byte = bmprgb_pkg::CmdColumnSet;
                    cur_byte.is_data  = 1'b0;
                end
                bmprgb_pkg::WinColHi:  cur_byte.bus_byte = 8'(head_job.x0 >> 8);
                bmprgb_pkg::WinColLo:  cur_byte.bus_byte = head_job.x0[7:0];
                bmprgb_pkg::WinColEHi: cur_byte.bus_byte = 8'(head_job.x1 >> 8);
                bmprgb_pkg::WinColELo: cur_byte.bus_byte = head_job.x1[7:0];
                bmprgb_pkg::WinPage:
                begin
                    cur_byte.bus_byte = bmprgb_pkg::CmdPageSet;
                    cur_byte.is_data  = 1'b0;
                end
                bmprgb_pkg::WinRowHi:  cur_byte.bus_byte = 8'(head_job.y0 >> 8);
                bmprgb_pkg::WinRowLo:  cur_byte.bus_byte = head_job.y0[7:0];
                bmprgb_pkg::WinRowEHi: cur_byte.bus_byte = 8'(head_job.y1 >> 8);
                bmprgb_pkg::WinRowELo: cur_byte.bus_byte = head_job.y1[7:0];
                bmprgb_pkg::WinLast:
                begin
                    cur_byte.bus_byte = bmprgb_pkg::CmdMemWrite;
                    cur_byte.is_data  = 1'b0;
                end
                default: ;
            endcase
        end
        cur_byte.last = job_done;
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        pop        = 1'b0;
        if (load)
        begin
            if (!q_status.empty)
            begin
                valid_next = 1'b1;
                data_next  = cur_byte;
                if (job_done)
                begin
                    pop      = 1'b1;
                    idx_next = bmprgb_pkg::JobFirst;
                end
                else
                begin
                    idx_next = idx_reg + bmprgb_pkg::JobIdxW'(1);
                end
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= bmprgb_pkg::JobFirst;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign bus_valid = valid_reg;
    assign bus_data  = data_reg;

endmodule

`default_nettype wire
